>>> hdl/nntr_pkg.sv
// ----------------------------------------------------------------------------
// nntr_pkg
// Shared types and constants of the nearest-neighbour tile resampler.
// ----------------------------------------------------------------------------
package nntr_pkg;

	localparam int CFG_W   = 10;
	localparam int COORD_W = 9;
	localparam int COORD_N = 512;
	localparam int PIX_W   = 32;
	localparam int IDX_W   = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_IN_WIDTH  = 2'd0,
		REG_IN_HEIGHT = 2'd1,
		REG_TILE_ROWS = 2'd2,
		REG_TILE_COLS = 2'd3
	} reg_idx_t;

	typedef enum logic [0:0] {
		CMD_LOAD  = 1'b0,
		CMD_FETCH = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_START,
		B_DIV1,
		B_DIV2,
		B_SWEEP
	} build_state_t;

	// One coordinate map entry: source index and whether it is usable.
	typedef struct packed {
		logic             v;
		logic [CFG_W-1:0] idx;
	} entry_t;

	typedef struct packed {
		cmd_t               cmd;
		logic               in_range;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PIX_W-1:0]   pixel;
	} item_t;

endpackage

>>> hdl/nntr_ram.sv
// ----------------------------------------------------------------------------
// nntr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module nntr_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 512,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/nntr_div.sv
// ----------------------------------------------------------------------------
// nntr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nntr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [nntr_pkg::CFG_W-1:0] n,
	input  logic [nntr_pkg::CFG_W-1:0] d,
	output logic                      done,
	output logic [nntr_pkg::CFG_W-1:0] q,
	output logic [nntr_pkg::CFG_W-1:0] r
);
	import nntr_pkg::*;

	localparam int CNT_W = $clog2(CFG_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] quo_q;
	logic [CFG_W-1:0] d_q;
	logic [CFG_W:0]   sh;
	logic             fits;

	assign sh   = {rem_q, quo_q[CFG_W-1]};
	assign fits = sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(CFG_W);
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= n;
			d_q   <= d;
		end else if (busy_q) begin
			rem_q <= fits ? CFG_W'(sh - {1'b0, d_q}) : sh[CFG_W-1:0];
			quo_q <= {quo_q[CFG_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign q    = quo_q;
	assign r    = rem_q;

endmodule

>>> hdl/nntr_axis.sv
// ----------------------------------------------------------------------------
// nntr_axis
// Coordinate map of one axis: output coordinate to source coordinate.
// Rebuilt after reset and after every register write.
// ----------------------------------------------------------------------------
module nntr_axis #(
	parameter int MAXV = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic [nntr_pkg::CFG_W-1:0]    size,
	input  logic [nntr_pkg::CFG_W-1:0]    count,
	output logic                          busy,
	input  logic                          rd_en,
	input  logic [nntr_pkg::COORD_W-1:0]  rd_addr,
	output nntr_pkg::entry_t              rd_data
);
	import nntr_pkg::*;

	localparam logic [12:0] MAXV_W = 13'(MAXV);

	build_state_t       state_q, state_d;
	logic               div_start, div_done, tbl_we;
	logic [CFG_W-1:0]   div_d, div_q, div_r;
	logic               err_q;
	logic [CFG_W-1:0]   cell_q, qs_q, q0_q, q_q, i_q;
	logic [CFG_W:0]     rs_q, r0_q, rem_q, two_ch, r0_d;
	logic [CFG_W+1:0]   sum;
	logic [COORD_W-1:0] k_q;
	logic               size_ok;
	entry_t             wr_ent;

	assign div_d = (state_q == B_START) ? count : div_q;

	nntr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.n     (size),
		.d     (div_d),
		.done  (div_done),
		.q     (div_q),
		.r     (div_r)
	);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		tbl_we    = 1'b0;
		case (state_q)
			B_IDLE: begin
			end
			B_START: begin
				if (count == '0) begin
					state_d = B_SWEEP;
				end else begin
					div_start = 1'b1;
					state_d   = B_DIV1;
				end
			end
			B_DIV1: begin
				if (div_done) begin
					if (div_q == '0) begin
						state_d = B_SWEEP;
					end else begin
						div_start = 1'b1;
						state_d   = B_DIV2;
					end
				end
			end
			B_DIV2: begin
				if (div_done) begin
					state_d = B_SWEEP;
				end
			end
			B_SWEEP: begin
				tbl_we = 1'b1;
				if (k_q == COORD_W'(COORD_N - 1)) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_START;
		end else if (restart) begin
			state_q <= B_START;
		end else begin
			state_q <= state_d;
		end
	end

	assign two_ch = {cell_q, 1'b0};
	assign sum    = {1'b0, rem_q} + {1'b0, rs_q};
	assign r0_d   = (div_q[0] ? {1'b0, cell_q} : '0) + {1'b0, div_r};

	always_ff @(posedge clk) begin
		case (state_q)
			B_START: begin
				err_q <= (count == '0);
				k_q   <= '0;
				i_q   <= '0;
				q_q   <= '0;
			end
			B_DIV1: begin
				if (div_done) begin
					cell_q <= div_q;
					if (div_q == '0) begin
						err_q <= 1'b1;
					end
				end
			end
			B_DIV2: begin
				// step of size/cell per coordinate, start at size/(2*cell)
				if (div_done) begin
					qs_q  <= div_q;
					rs_q  <= {div_r, 1'b0};
					q0_q  <= {1'b0, div_q[CFG_W-1:1]};
					q_q   <= {1'b0, div_q[CFG_W-1:1]};
					r0_q  <= r0_d;
					rem_q <= r0_d;
				end
			end
			B_SWEEP: begin
				k_q <= k_q + 1'b1;
				if (i_q == cell_q - 1'b1) begin
					i_q   <= '0;
					q_q   <= q0_q;
					rem_q <= r0_q;
				end else begin
					i_q <= i_q + 1'b1;
					if (sum >= {1'b0, two_ch}) begin
						rem_q <= CFG_W'(sum - {1'b0, two_ch}) | {1'b0, {CFG_W{1'b0}}};
						q_q   <= q_q + qs_q + 1'b1;
					end else begin
						rem_q <= sum[CFG_W:0];
						q_q   <= q_q + qs_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign size_ok   = {3'b0, size} <= MAXV_W;
	assign wr_ent.v  = !err_q && size_ok && ({1'b0, k_q} < size) && (q_q < size);
	assign wr_ent.idx = q_q;
	assign busy      = (state_q != B_IDLE);

	nntr_ram #(
		.W    ($bits(entry_t)),
		.DEPTH(COORD_N)
	) u_map (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(k_q),
		.wdata(wr_ent),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

endmodule

>>> hdl/nntr_front.sv
// ----------------------------------------------------------------------------
// nntr_front
// Input side: takes items, marks those inside the store, queues them.
// ----------------------------------------------------------------------------
module nntr_front #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hold,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [55:0]         s_tdata,
	input  logic [0:0]          s_tuser,
	input  logic                pop,
	output logic                empty,
	output nntr_pkg::item_t     head
);
	import nntr_pkg::*;

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	item_t       fifo_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          push, do_pop;
	item_t         in_item;

	assign in_item.cmd      = cmd_t'(s_tuser[0]);
	assign in_item.row      = s_tdata[COORD_W-1:0];
	assign in_item.col      = s_tdata[2*COORD_W-1:COORD_W];
	assign in_item.pixel    = s_tdata[2*COORD_W+PIX_W-1:2*COORD_W];
	assign in_item.in_range = (32'(in_item.row) < 32'(MAX_HEIGHT)) &&
	                          (32'(in_item.col) < 32'(MAX_WIDTH));

	assign s_tready = (cnt_q != (PW+1)'(DEPTH)) && !hold;
	assign push     = s_tvalid && s_tready;
	assign empty    = (cnt_q == '0);
	assign do_pop   = pop && !empty;
	assign head     = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= in_item;
		end
	end

endmodule

>>> hdl/nearest_neighbour_tile_resampler_core.sv
// ----------------------------------------------------------------------------
// nearest_neighbour_tile_resampler_core
// Frame store with tiled nearest-neighbour readout.
// ----------------------------------------------------------------------------
// Input items arrive on s_tvalid/s_tready: s_tuser selects load (0) or fetch
// (1), s_tdata carries row, col and pixel. A load writes one source pixel and
// gives no result; a fetch gives one result on m_tvalid/m_tready with the
// tiled output pixel in m_tdata and the error flag in m_tuser.
// Registers are written on cfg_valid/cfg_ready (always ready), cfg_index
// selects in_width, in_height, tile_rows or tile_cols.
// Throughput is one item per cycle while the receiver is ready and no map is
// being rebuilt; a fetch result passes queue, map read, address, frame store
// read and output register. After reset and after every register write, each
// axis rebuilds its coordinate map (up to two divisions, then a sweep of all
// 512 entries) while s_tready stays low. A stalled receiver freezes the back
// pipeline; the 4-entry queue keeps accepting until it fills.
// ----------------------------------------------------------------------------
module nearest_neighbour_tile_resampler_core #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [55:0]                    s_tdata,   // row, col, pixel, zero pad
	input  logic [0:0]                     s_tuser,   // command
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [nntr_pkg::PIX_W-1:0]     m_tdata,   // out_pixel
	output logic [0:0]                     m_tuser,   // error
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [nntr_pkg::IDX_W-1:0]     cfg_index,
	input  logic [nntr_pkg::CFG_W-1:0]     cfg_data
);
	import nntr_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CFG_W-1:0] width_q, height_q, trows_q, tcols_q;
	logic             cfg_wr, row_busy, col_busy, adv, pop, empty;
	item_t            head;
	entry_t           rent, cent;

	logic             v_s1, inr_s1;
	cmd_t             cmd_s1;
	logic [COORD_W-1:0] row_s1, col_s1;
	logic [PIX_W-1:0] pixel_s1;

	logic             v_s2, load_s2, fetch_s2, err_s2;
	logic [AW-1:0]    addr_s2;
	logic [PIX_W-1:0] pixel_s2;

	logic             v_s3, err_s3;
	logic [PIX_W-1:0] rdata_s3;

	logic             out_v_q, out_err_q;
	logic [PIX_W-1:0] out_pix_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(512);
			height_q <= CFG_W'(512);
			trows_q  <= CFG_W'(1);
			tcols_q  <= CFG_W'(1);
		end else if (cfg_wr) begin
			case (reg_idx_t'(cfg_index))
				REG_IN_WIDTH:  width_q  <= cfg_data;
				REG_IN_HEIGHT: height_q <= cfg_data;
				REG_TILE_ROWS: trows_q  <= cfg_data;
				REG_TILE_COLS: tcols_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign adv = !out_v_q || m_tready;
	assign pop = adv && !empty;

	nntr_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.hold    (row_busy || col_busy),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.pop     (pop),
		.empty   (empty),
		.head    (head)
	);

	nntr_axis #(.MAXV(MAX_HEIGHT)) u_rows (
		.clk    (clk),
		.arst_n (arst_n),
		.restart(cfg_wr),
		.size   (height_q),
		.count  (trows_q),
		.busy   (row_busy),
		.rd_en  (pop),
		.rd_addr(head.row),
		.rd_data(rent)
	);

	nntr_axis #(.MAXV(MAX_WIDTH)) u_cols (
		.clk    (clk),
		.arst_n (arst_n),
		.restart(cfg_wr),
		.size   (width_q),
		.count  (tcols_q),
		.busy   (col_busy),
		.rd_en  (pop),
		.rd_addr(head.col),
		.rd_data(cent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= pop;
			v_s2    <= v_s1;
			v_s3    <= v_s2 && fetch_s2;
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1   <= head.cmd;
			inr_s1   <= head.in_range;
			row_s1   <= head.row;
			col_s1   <= head.col;
			pixel_s1 <= head.pixel;

			load_s2  <= (cmd_s1 == CMD_LOAD) && inr_s1;
			fetch_s2 <= (cmd_s1 == CMD_FETCH);
			err_s2   <= !(rent.v && cent.v);
			pixel_s2 <= pixel_s1;
			if (cmd_s1 == CMD_LOAD) begin
				addr_s2 <= AW'(32'(row_s1) * 32'(MAX_WIDTH) + 32'(col_s1));
			end else begin
				addr_s2 <= AW'(32'(rent.idx) * 32'(MAX_WIDTH) + 32'(cent.idx));
			end

			err_s3 <= err_s2;

			out_err_q <= err_s3;
			out_pix_q <= err_s3 ? '0 : rdata_s3;
		end
	end

	// loads and fetches reach the store in arrival order at the same stage
	nntr_ram #(
		.W    (PIX_W),
		.DEPTH(DEPTH)
	) u_frame (
		.clk  (clk),
		.we   (adv && v_s2 && load_s2),
		.waddr(addr_s2),
		.wdata(pixel_s2),
		.re   (adv && v_s2 && fetch_s2),
		.raddr(addr_s2),
		.rdata(rdata_s3)
	);

	assign m_tvalid   = out_v_q;
	assign m_tdata    = out_pix_q;
	assign m_tuser[0] = out_err_q;

endmodule
